// ----- design/mfs_pkg.sv -----
package mfs_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int LEVELS       = 3;
    localparam int BOTTOM_LEVEL = 2;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LVL_W     = 2;
    localparam int ID_W      = 8;
    localparam int WORK_W    = 16;
    localparam int SLICE_W   = 8;
    localparam int ENTRY_W   = ID_W + WORK_W;

    // Input item kinds.
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_TOP_SLICE    = 2'd0;
    localparam logic [1:0] REG_MIDDLE_SLICE = 2'd1;
    localparam logic [1:0] REG_BOTTOM_SLICE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_LOAD   = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    typedef struct packed {
        logic capture;
        logic arrive;
        logic fetch;
        logic load;
        logic run;
        logic idle_tick;
    } cmd_t;

    typedef struct packed {
        logic             is_tick;
        logic             slice_active;
        logic             any_ready;
        logic [CNT_W-1:0] held;
    } status_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] lv,
                                                   input logic [PTR_W-1:0] ptr);
        return ADDR_W'(int'(lv) * QUEUE_DEPTH + int'(ptr));
    endfunction

endpackage

// ----- design/mfs_ctrl.sv -----
module mfs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mfs_pkg::status_t  status,
    output mfs_pkg::cmd_t     cmd
);

    mfs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            mfs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = mfs_pkg::ST_DECIDE;
                end
            end
            mfs_pkg::ST_DECIDE: begin
                if (!status.is_tick) begin
                    cmd.arrive = 1'b1;
                    state_next = mfs_pkg::ST_OUT;
                end else if (status.slice_active) begin
                    state_next = mfs_pkg::ST_RUN;
                end else if (status.any_ready) begin
                    // The head entry is read here and lands in the read register.
                    cmd.fetch  = 1'b1;
                    state_next = mfs_pkg::ST_LOAD;
                end else begin
                    cmd.idle_tick = 1'b1;
                    state_next    = mfs_pkg::ST_OUT;
                end
            end
            mfs_pkg::ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = mfs_pkg::ST_RUN;
            end
            mfs_pkg::ST_RUN: begin
                cmd.run    = 1'b1;
                state_next = mfs_pkg::ST_OUT;
            end
            mfs_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = mfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/mfs_dpath.sv -----
module mfs_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mfs_pkg::cmd_t                       cmd,
    input  logic                                in_action,
    input  logic [mfs_pkg::ID_W-1:0]            in_task_id,
    input  logic [mfs_pkg::WORK_W-1:0]          in_work_needed,
    input  logic [mfs_pkg::SLICE_W-1:0]         top_slice,
    input  logic [mfs_pkg::SLICE_W-1:0]         middle_slice,
    input  logic [mfs_pkg::SLICE_W-1:0]         bottom_slice,
    output mfs_pkg::status_t                    status,
    output logic                                ran,
    output logic [mfs_pkg::ID_W-1:0]            ran_task,
    output logic [mfs_pkg::LVL_W-1:0]           ran_level,
    output logic                                completed,
    output logic                                refused
);

    // Captured input item.
    logic                           action_reg;
    logic [mfs_pkg::ID_W-1:0]       id_reg;
    logic [mfs_pkg::WORK_W-1:0]     work_reg;

    // Queue bookkeeping.
    logic [mfs_pkg::PTR_W-1:0]      head_reg  [mfs_pkg::LEVELS];
    logic [mfs_pkg::PTR_W-1:0]      tail_reg  [mfs_pkg::LEVELS];
    logic [mfs_pkg::CNT_W-1:0]      count_reg [mfs_pkg::LEVELS];
    logic [mfs_pkg::CNT_W-1:0]      held_reg;

    // Running task.
    logic                           slice_active_reg;
    logic [mfs_pkg::ID_W-1:0]       run_id_reg;
    logic [mfs_pkg::WORK_W-1:0]     run_left_reg;
    logic [mfs_pkg::LVL_W-1:0]      run_level_reg;
    logic [mfs_pkg::SLICE_W-1:0]    slice_left_reg;

    // Result register.
    logic                           res_ran_reg;
    logic [mfs_pkg::ID_W-1:0]       res_id_reg;
    logic [mfs_pkg::LVL_W-1:0]      res_level_reg;
    logic                           res_done_reg;
    logic                           res_refused_reg;

    // Entry store: all levels share one memory, each level owning a ring.
    logic [mfs_pkg::ENTRY_W-1:0]    mem [mfs_pkg::MEM_DEPTH];
    logic [mfs_pkg::ENTRY_W-1:0]    rd_data_reg;

    logic [mfs_pkg::LVL_W-1:0]      pick_lvl;
    logic                           any_ready;
    logic                           full;
    logic [mfs_pkg::WORK_W-1:0]     arr_work;
    logic [mfs_pkg::WORK_W-1:0]     left_dec;
    logic [mfs_pkg::SLICE_W-1:0]    slice_dec;
    logic [mfs_pkg::LVL_W-1:0]      dst_lvl;
    logic                           push_req;
    logic                           push_en;
    logic                           push_dem;
    logic [mfs_pkg::LVL_W-1:0]      push_lvl;
    logic [mfs_pkg::ENTRY_W-1:0]    push_data;
    logic [mfs_pkg::SLICE_W-1:0]    pick_slice;
    logic                           done_now;

    // The lowest-numbered (top) nonempty level wins.
    always_comb begin
        any_ready = 1'b0;
        pick_lvl  = '0;
        for (int l = mfs_pkg::LEVELS - 1; l >= 0; l--) begin
            if (count_reg[l] != '0) begin
                any_ready = 1'b1;
                pick_lvl  = mfs_pkg::LVL_W'(l);
            end
        end
    end

    always_comb begin
        unique case (pick_lvl)
            2'd0:    pick_slice = top_slice;
            2'd1:    pick_slice = middle_slice;
            default: pick_slice = bottom_slice;
        endcase
        if (pick_slice == '0) begin
            pick_slice = mfs_pkg::SLICE_W'(1);
        end
    end

    assign full     = (held_reg >= mfs_pkg::CNT_W'(mfs_pkg::QUEUE_DEPTH));
    assign arr_work = (work_reg == '0) ? mfs_pkg::WORK_W'(1) : work_reg;
    assign left_dec = (run_left_reg != '0) ? run_left_reg - 1'b1 : run_left_reg;
    assign slice_dec = (slice_left_reg != '0) ? slice_left_reg - 1'b1 : slice_left_reg;
    assign done_now = (left_dec == '0);
    assign dst_lvl  = (run_level_reg == mfs_pkg::LVL_W'(mfs_pkg::BOTTOM_LEVEL)) ?
                      run_level_reg : run_level_reg + 1'b1;

    assign push_dem  = cmd.run && !done_now && (slice_dec == '0);
    assign push_req  = push_dem || (cmd.arrive && !full);
    assign push_lvl  = push_dem ? dst_lvl : '0;
    assign push_data = push_dem ? {left_dec, run_id_reg} : {arr_work, id_reg};
    assign push_en   = push_req && (count_reg[push_lvl] != mfs_pkg::CNT_W'(mfs_pkg::QUEUE_DEPTH));

    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[mfs_pkg::mem_addr(push_lvl, tail_reg[push_lvl])] <= push_data;
        end
        if (cmd.fetch) begin
            rd_data_reg <= mem[mfs_pkg::mem_addr(pick_lvl, head_reg[pick_lvl])];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= in_action;
            id_reg     <= in_task_id;
            work_reg   <= in_work_needed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else begin
            for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
                if (push_en && push_lvl == mfs_pkg::LVL_W'(l)) begin
                    tail_reg[l]  <= mfs_pkg::next_slot(tail_reg[l]);
                    count_reg[l] <= count_reg[l] + 1'b1;
                end
                if (cmd.fetch && pick_lvl == mfs_pkg::LVL_W'(l)) begin
                    head_reg[l]  <= mfs_pkg::next_slot(head_reg[l]);
                    count_reg[l] <= count_reg[l] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg         <= '0;
            slice_active_reg <= 1'b0;
            run_id_reg       <= '0;
            run_left_reg     <= '0;
            run_level_reg    <= '0;
            slice_left_reg   <= '0;
        end else begin
            if (cmd.arrive && !full) begin
                held_reg <= held_reg + 1'b1;
            end
            if (cmd.fetch) begin
                run_level_reg    <= pick_lvl;
                slice_left_reg   <= pick_slice;
                slice_active_reg <= 1'b1;
            end
            if (cmd.load) begin
                run_id_reg   <= rd_data_reg[mfs_pkg::ID_W-1:0];
                run_left_reg <= rd_data_reg[mfs_pkg::ENTRY_W-1:mfs_pkg::ID_W];
            end
            if (cmd.run) begin
                run_left_reg   <= left_dec;
                slice_left_reg <= slice_dec;
                if (done_now) begin
                    slice_active_reg <= 1'b0;
                    if (held_reg != '0) begin
                        held_reg <= held_reg - 1'b1;
                    end
                end else if (slice_dec == '0) begin
                    slice_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.arrive || cmd.idle_tick) begin
            res_ran_reg     <= 1'b0;
            res_id_reg      <= '0;
            res_level_reg   <= '0;
            res_done_reg    <= 1'b0;
            res_refused_reg <= cmd.arrive && full;
        end else if (cmd.run) begin
            res_ran_reg     <= 1'b1;
            res_id_reg      <= run_id_reg;
            res_level_reg   <= run_level_reg;
            res_done_reg    <= done_now;
            res_refused_reg <= 1'b0;
        end
    end

    assign status.is_tick      = (action_reg == mfs_pkg::ACT_TICK);
    assign status.slice_active = slice_active_reg;
    assign status.any_ready    = any_ready;
    assign status.held         = held_reg;

    assign ran       = res_ran_reg;
    assign ran_task  = res_id_reg;
    assign ran_level = res_level_reg;
    assign completed = res_done_reg;
    assign refused   = res_refused_reg;

endmodule

// ----- design/multilevel_feedback_scheduler.sv -----
// Three-level feedback queue scheduler. Each input item is either a task arrival or one
// time tick, and each item yields exactly one result item. Items are handled one at a
// time. An arrival, or a tick that finds nothing to run, passes through DECIDE to OUT,
// where its result is offered. A tick that continues a running slice goes DECIDE, RUN, OUT.
// A tick that starts a new slice goes DECIDE, LOAD, RUN, OUT, because the head entry must
// first be read from the queue memory into the read register and loaded into the
// running-task registers. The next item can be accepted in the cycle after the result is
// taken. The user must write slice lengths through the APB port only while no item is in
// flight; the block itself does not enforce this. A slice of zero acts as one.
module multilevel_feedback_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id[7:0], work_needed[23:8]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // ran_task[7:0], ran_level[9:8], zero[15:10]
    output logic [2:0]  m_tuser,   // ran[0], completed[1], refused[2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [mfs_pkg::SLICE_W-1:0] top_slice_reg;
    logic [mfs_pkg::SLICE_W-1:0] middle_slice_reg;
    logic [mfs_pkg::SLICE_W-1:0] bottom_slice_reg;
    logic [1:0]                  reg_index;
    logic                        cfg_write;

    mfs_pkg::cmd_t               cmd;
    mfs_pkg::status_t            status;

    logic                        ran;
    logic [mfs_pkg::ID_W-1:0]    ran_task;
    logic [mfs_pkg::LVL_W-1:0]   ran_level;
    logic                        completed;
    logic                        refused;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_slice_reg    <= mfs_pkg::SLICE_W'(1);
            middle_slice_reg <= mfs_pkg::SLICE_W'(2);
            bottom_slice_reg <= mfs_pkg::SLICE_W'(4);
        end else if (cfg_write) begin
            unique case (reg_index)
                mfs_pkg::REG_TOP_SLICE:    top_slice_reg    <= pwdata[7:0];
                mfs_pkg::REG_MIDDLE_SLICE: middle_slice_reg <= pwdata[7:0];
                mfs_pkg::REG_BOTTOM_SLICE: bottom_slice_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            mfs_pkg::REG_TOP_SLICE:    prdata = {24'd0, top_slice_reg};
            mfs_pkg::REG_MIDDLE_SLICE: prdata = {24'd0, middle_slice_reg};
            mfs_pkg::REG_BOTTOM_SLICE: prdata = {24'd0, bottom_slice_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    mfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mfs_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_action      (s_tuser[0]),
        .in_task_id     (s_tdata[7:0]),
        .in_work_needed (s_tdata[23:8]),
        .top_slice      (top_slice_reg),
        .middle_slice   (middle_slice_reg),
        .bottom_slice   (bottom_slice_reg),
        .status         (status),
        .ran            (ran),
        .ran_task       (ran_task),
        .ran_level      (ran_level),
        .completed      (completed),
        .refused        (refused)
    );

    assign m_tdata = {6'd0, ran_level, ran_task};
    assign m_tuser = {refused, completed, ran};

    // One item at a time: never accepting while a result is pending.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_done_implies_ran: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("completion reported without a running task");

    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[9:0] == 10'd0))
        else $error("task fields nonzero when nothing ran");

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.held <= mfs_pkg::CNT_W'(mfs_pkg::QUEUE_DEPTH))
        else $error("held task count exceeds queue depth");

endmodule
